FILE: sv/mft_pkg.sv
// Shared types, constants and the byte encoder for the Manchester frame transmitter.
// Used by the core, the top level and the port checker. No dependencies.
package mft_pkg;

    // Default payload store depth
    localparam int MAX_PAYLOAD_DEF = 32;

    // Half-bits in one line word and the width of its down counter
    localparam int WORD_HALF_BITS = 20;
    localparam int HALF_W         = $clog2(WORD_HALF_BITS + 1);

    // Preamble (three bytes), sync and STX precede the payload
    localparam int HEADER_BYTES   = 5;
    localparam int PREAMBLE_COUNT = 3;

    // Line words
    localparam logic [WORD_HALF_BITS-1:0] IDLE_WORD  = 20'hAAAAA;
    localparam logic [WORD_HALF_BITS-1:0] RESET_WORD = 20'hFFFFF;

    // Frame bytes
    localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0] SYNC_BYTE     = 8'hD5;
    localparam logic [7:0] START_TEXT    = 8'h02;
    localparam logic [7:0] END_TEXT      = 8'h03;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_SEND   = 2'd2
    } mode_t;

    // Result codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // One result item
    typedef struct packed {
        logic    available;
        status_t status;
        logic    line_level;
    } mft_result_t;

    // Byte to 20 half-bit word, sent LSB first:
    // start (1,0), data LSB first (one = 0,1; zero = 1,0), stop (0,1)
    function automatic logic [WORD_HALF_BITS-1:0] encode_word(input logic [7:0] byte_in);
        logic [WORD_HALF_BITS-1:0] w;
        begin
            w = '0;
            w[1:0]   = 2'b01;
            w[19:18] = 2'b10;
            for (int i = 0; i < 8; i++)
            begin
                w[2 + 2 * i +: 2] = byte_in[i] ? 2'b10 : 2'b01;
            end
            return w;
        end
    endfunction

endpackage

FILE: sv/mft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mft_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/mft_core.sv
// Transmitter state: payload store, frame sequencer and half-bit shifter.
// Processes one item per step and returns its result. Depends on mft_pkg, mft_ram.
module mft_core
    import mft_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output mft_result_t result
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W  = $clog2(MAX_PAYLOAD + HEADER_BYTES + 2);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(MAX_PAYLOAD);
    localparam logic [POS_W-1:0]  HDR_POS   = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0]  SYNC_POS  = POS_W'(PREAMBLE_COUNT);
    localparam logic [POS_W-1:0]  STX_POS   = POS_W'(PREAMBLE_COUNT + 1);
    localparam logic [POS_W-1:0]  EXTRA_LEN = POS_W'(HEADER_BYTES + 1);
    localparam logic [HALF_W-1:0] LAST_HALF = HALF_W'(1);
    localparam logic [HALF_W-1:0] FULL_HALF = HALF_W'(WORD_HALF_BITS);

    logic [CNT_W-1:0]          fill_count_reg, fill_count_next;
    logic [POS_W-1:0]          frame_pos_reg, frame_pos_next;
    logic [POS_W-1:0]          frame_len_reg, frame_len_next;
    logic                      frame_active_reg, frame_active_next;
    logic [WORD_HALF_BITS-1:0] shifter_reg, shifter_next;
    logic [HALF_W-1:0]         left_reg, left_next;
    logic                      line_reg, line_next;
    status_t                   status;

    logic                      wr_en;
    logic [POS_W-1:0]          payload_idx;
    logic [7:0]                rd_data;
    logic [7:0]                next_byte;

    // Payload store; read address follows the frame position, so data is
    // ready long before the word that needs it ends
    assign wr_en       = step && (mode == MODE_APPEND) && !frame_active_reg
                         && (fill_count_reg != FULL_CNT);
    assign payload_idx = frame_pos_reg - HDR_POS;

    mft_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_count_reg[ADDR_W-1:0]),
        .wr_data (data_byte),
        .rd_addr (payload_idx[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Byte due at the current frame position
    always_comb
    begin
        if (frame_pos_reg < SYNC_POS)
        begin
            next_byte = PREAMBLE_BYTE;
        end
        else if (frame_pos_reg == SYNC_POS)
        begin
            next_byte = SYNC_BYTE;
        end
        else if (frame_pos_reg == STX_POS)
        begin
            next_byte = START_TEXT;
        end
        else if (payload_idx < POS_W'(fill_count_reg))
        begin
            next_byte = rd_data;
        end
        else
        begin
            next_byte = END_TEXT;
        end
    end

    // Next state and status for the item in hand
    always_comb
    begin
        fill_count_next   = fill_count_reg;
        frame_pos_next    = frame_pos_reg;
        frame_len_next    = frame_len_reg;
        frame_active_next = frame_active_reg;
        shifter_next      = shifter_reg;
        left_next         = left_reg;
        line_next         = line_reg;
        status            = ST_OK;

        case (mode)
            MODE_TICK:
            begin
                line_next    = shifter_reg[0];
                left_next    = left_reg - LAST_HALF;
                shifter_next = shifter_reg >> 1;
                // word end: load next frame word or idle pattern
                if (left_reg == LAST_HALF)
                begin
                    shifter_next = IDLE_WORD;
                    if (frame_active_reg)
                    begin
                        if (frame_pos_reg < frame_len_reg)
                        begin
                            shifter_next   = encode_word(next_byte);
                            frame_pos_next = frame_pos_reg + POS_W'(1);
                        end
                        else
                        begin
                            frame_active_next = 1'b0;
                            frame_pos_next    = '0;
                            frame_len_next    = '0;
                            fill_count_next   = '0;
                        end
                    end
                    left_next = FULL_HALF;
                end
            end
            MODE_APPEND:
            begin
                if (frame_active_reg)
                begin
                    status = ST_BUSY;
                end
                else if (fill_count_reg == FULL_CNT)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    fill_count_next = fill_count_reg + CNT_W'(1);
                end
            end
            MODE_SEND:
            begin
                if (frame_active_reg)
                begin
                    status = ST_BUSY;
                end
                else
                begin
                    frame_active_next = 1'b1;
                    frame_pos_next    = '0;
                    frame_len_next    = POS_W'(fill_count_reg) + EXTRA_LEN;
                end
            end
            default:
            begin
                status = ST_BUSY;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            frame_pos_reg    <= '0;
            frame_len_reg    <= '0;
            frame_active_reg <= 1'b0;
            shifter_reg      <= RESET_WORD;
            left_reg         <= FULL_HALF;
            line_reg         <= 1'b0;
        end
        else if (step)
        begin
            fill_count_reg   <= fill_count_next;
            frame_pos_reg    <= frame_pos_next;
            frame_len_reg    <= frame_len_next;
            frame_active_reg <= frame_active_next;
            shifter_reg      <= shifter_next;
            left_reg         <= left_next;
            line_reg         <= line_next;
        end
    end

    assign result.line_level = line_next;
    assign result.status     = status;
    assign result.available  = !frame_active_next;

endmodule

FILE: sv/manchester_frame_transmitter_unit.sv
// Top level of the Manchester frame transmitter: input register, core, result register.
// Depends on mft_pkg and mft_core.
//
// Usage:
//   Slave channel s_*: one item per transfer. s_tuser carries the kind (half-bit
//   tick, append payload byte, send frame), s_tdata the payload byte.
//   Master channel m_*: exactly one result per input item, in order. m_tdata
//   carries line level, status and available.
//   Flow: a result passes from the input register to the result register and is
//   presented on m_* until a clock edge with m_tready high takes it. Throughput
//   is one item per cycle while m_tready stays high; the core updates its
//   state in the cycle an item leaves the input register.
//   Stall: while a result waits in the output register with m_tready low, the
//   input register still takes one more item; after that s_tready drops until
//   the result is taken. Nothing is lost or repeated.
//   Reset: both registers empty, no frame active, payload store empty, and the
//   line sends ones for the first 20 half-bits. Store contents are not cleared;
//   a frame only reads bytes appended since the last send.
module manchester_frame_transmitter_unit
    import mft_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] line_level, [2:1] status, [3] available, [7:4] zero
);

    logic        in_valid_reg;
    logic [1:0]  in_mode_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    mft_result_t out_result_reg;
    mft_result_t core_result;
    logic        advance;

    // Item moves from the input register into the core and result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    mft_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .mode      (in_mode_reg),
        .data_byte (in_data_reg),
        .result    (core_result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_result_reg};

endmodule

FILE: sv/mft_checker.sv
// Port-level checker for the Manchester frame transmitter and its bind to the top level.
// Depends on mft_pkg and manchester_frame_transmitter_unit.
module mft_checker
    import mft_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // With no result pending the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A full-store drop only happens while no frame is going out
    a_full_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:1] == ST_FULL) |-> m_tdata[3])
        else $error("store-full status during a frame");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] == 4'b0000))
        else $error("nonzero padding in result");

    // A pending input transfer keeps its valid until taken
    a_in_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("input valid dropped while stalled");

endmodule

bind manchester_frame_transmitter_unit mft_checker u_mft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
